// File: rtl/wvd_pkg.sv
// shared constants, types and helpers of the wave vector decompose pipeline
package wvd_pkg;

  // root bits of the square root pipe (32-bit radicand)
  localparam int WVD_ROOT_BITS = 16;
  // quotient bits of the divider pipe
  localparam int WVD_QUO_BITS  = 29;
  // floor(floor(2*pi * 2^28) / 4096), wavelength numerator once the q12 shift is folded in
  localparam logic [18:0] WVD_LEN_NUM = 19'd411774;
  localparam logic [15:0] WVD_UNIT_MAX = 16'd16384;
  localparam logic [16:0] WVD_PROD_MAX = 17'd32768;

  // per-item data that rides alongside the arithmetic pipes
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic        sx;
    logic        sy;
    logic        zero;
  } wvd_side_t;

  // saturate a product magnitude
  function automatic logic [16:0] wvd_prod_clamp(input logic [16:0] m);
    wvd_prod_clamp = (m > WVD_PROD_MAX) ? WVD_PROD_MAX : m;
  endfunction

endpackage

// File: rtl/wvd_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
module wvd_sqrt_pipe
  import wvd_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] rad,
  output logic [15:0] root
);

  logic [31:0] rad_s  [1:WVD_ROOT_BITS];
  logic [16:0] rem_s  [1:WVD_ROOT_BITS];
  logic [15:0] root_s [1:WVD_ROOT_BITS];

  for (genvar i = 0; i < WVD_ROOT_BITS; i++) begin : g_stage
    logic [31:0] rad_in;
    logic [16:0] rem_in;
    logic [15:0] root_in;
    logic [18:0] rem_sh;
    logic [18:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rad_in  = rad_s[i];
      assign rem_in  = rem_s[i];
      assign root_in = root_s[i];
    end

    assign rem_sh = {rem_in, rad_in[31:30]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      rad_s[i+1]  <= {rad_in[29:0], 2'b00};
      root_s[i+1] <= {root_in[14:0], ge};
      if (ge) begin
        rem_s[i+1] <= 17'(rem_sh - trial);
      end else begin
        rem_s[i+1] <= rem_sh[16:0];
      end
    end
  end

  assign root = root_s[WVD_ROOT_BITS];

endmodule

// File: rtl/wvd_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module wvd_div_pipe
  import wvd_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] rem0,
  input  logic [28:0] low,
  input  logic [31:0] divisor,
  output logic [28:0] quo
);

  logic [31:0] rem_s [1:WVD_QUO_BITS];
  logic [28:0] low_s [1:WVD_QUO_BITS];
  logic [31:0] div_s [1:WVD_QUO_BITS];
  logic [28:0] quo_s [1:WVD_QUO_BITS];

  for (genvar i = 0; i < WVD_QUO_BITS; i++) begin : g_stage
    logic [31:0] rem_in;
    logic [28:0] low_in;
    logic [31:0] div_in;
    logic [28:0] quo_in;
    logic [32:0] rem_sh;
    logic [32:0] dv;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_in = rem0;
      assign low_in = low;
      assign div_in = divisor;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_s[i];
      assign low_in = low_s[i];
      assign div_in = div_s[i];
      assign quo_in = quo_s[i];
    end

    assign rem_sh = {rem_in, low_in[28]};
    assign dv     = {1'b0, div_in};
    assign ge     = (rem_sh >= dv);

    always_ff @(posedge clk) begin
      low_s[i+1] <= {low_in[27:0], 1'b0};
      div_s[i+1] <= div_in;
      quo_s[i+1] <= {quo_in[27:0], ge};
      if (ge) begin
        rem_s[i+1] <= 32'(rem_sh - dv);
      end else begin
        rem_s[i+1] <= rem_sh[31:0];
      end
    end
  end

  assign quo = quo_s[WVD_QUO_BITS];

endmodule

// File: rtl/wave_vector_decompose.sv
// top level: wave vector magnitude, wavelength, unit vector and products
//
// one transaction (kx, ky) is taken in every cycle that start is high; busy
// never rises. each transaction gives exactly one result, marked by done
// for one cycle, in order. the depth is set by two chains of bit-per-stage
// units: the magnitude root (16 stages) feeding the wavelength divider
// (29 stages), and in parallel the unit-vector divider (29 stages) feeding
// a second root (16 stages); three stages in front form |k| and the sum of
// squares, three behind form the products. the receiver cannot stall, so
// nothing here ever holds a result back.
module wave_vector_decompose
  import wvd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] kx,
  input  logic signed [15:0] ky,
  output logic               done,
  output logic        [15:0] wavenumber,
  output logic        [18:0] wavelength,
  output logic signed [15:0] unit_x,
  output logic signed [15:0] unit_y,
  output logic        [15:0] kx_times_ux,
  output logic        [15:0] ky_times_uy,
  output logic signed [16:0] kx_times_uy
);

  localparam int MidDepth = WVD_ROOT_BITS + WVD_QUO_BITS;

  // stage 1: magnitudes and signs
  logic        v1;
  logic [15:0] ax1, ay1;
  logic        sx1, sy1;
  // stage 2: squares
  logic        v2;
  logic [31:0] axsq2, aysq2;
  logic [15:0] ax2, ay2;
  logic        sx2, sy2;
  // stage 3: sum of squares
  logic        v3;
  logic [31:0] s3, axsq3, aysq3;
  wvd_side_t   side3;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    // full-scale negative maps to 32768 as unsigned
    ax1   <= kx[15] ? 16'(-kx) : kx;
    ay1   <= ky[15] ? 16'(-ky) : ky;
    sx1   <= kx[15];
    sy1   <= ky[15];
    axsq2 <= ax1 * ax1;
    aysq2 <= ay1 * ay1;
    ax2   <= ax1;
    ay2   <= ay1;
    sx2   <= sx1;
    sy2   <= sy1;
    s3    <= 32'(axsq2 + aysq2);
    axsq3 <= axsq2;
    aysq3 <= aysq2;
    side3 <= '{ax: ax2, ay: ay2, sx: sx2, sy: sy2, zero: (ax2 == '0) && (ay2 == '0)};
  end

  // magnitude root, then wavelength division
  logic [15:0] mag;
  logic [28:0] len_q;

  wvd_sqrt_pipe u_mag_sqrt (
    .clk  (clk),
    .rad  (s3),
    .root (mag)
  );

  wvd_div_pipe u_len_div (
    .clk     (clk),
    .rem0    ('0),
    .low     ({10'b0, WVD_LEN_NUM}),
    .divisor ({16'b0, mag}),
    .quo     (len_q)
  );

  // unit components: root of (a^2 << 28) / s
  logic [28:0] qx, qy;
  logic [15:0] ux_raw, uy_raw;

  wvd_div_pipe u_ux_div (
    .clk     (clk),
    .rem0    ({1'b0, axsq3[31:1]}),
    .low     ({axsq3[0], 28'b0}),
    .divisor (s3),
    .quo     (qx)
  );

  wvd_div_pipe u_uy_div (
    .clk     (clk),
    .rem0    ({1'b0, aysq3[31:1]}),
    .low     ({aysq3[0], 28'b0}),
    .divisor (s3),
    .quo     (qy)
  );

  wvd_sqrt_pipe u_ux_sqrt (
    .clk  (clk),
    .rad  ({3'b0, qx}),
    .root (ux_raw)
  );

  wvd_sqrt_pipe u_uy_sqrt (
    .clk  (clk),
    .rad  ({3'b0, qy}),
    .root (uy_raw)
  );

  // side data and valid bits matched to the arithmetic depth
  logic [MidDepth-1:0] vld;
  wvd_side_t           side_d [1:MidDepth];
  logic [15:0]         mag_d  [1:WVD_QUO_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[MidDepth-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    side_d[1] <= side3;
    for (int i = 2; i <= MidDepth; i++) begin
      side_d[i] <= side_d[i-1];
    end
    mag_d[1] <= mag;
    for (int i = 2; i <= WVD_QUO_BITS; i++) begin
      mag_d[i] <= mag_d[i-1];
    end
  end

  wvd_side_t sd;
  assign sd = side_d[MidDepth];

  // stage p1: clamp unit magnitudes, zero vector forces the unit magnitudes and wavelength to zero
  logic        v4;
  logic [14:0] uxm4, uym4;
  logic [18:0] len4;
  logic [15:0] mag4;
  logic [15:0] ax4, ay4;
  logic        sx4, sy4;
  // stage p2: signed units and product magnitudes
  logic        v5;
  logic [30:0] mxx5, myy5, mxy5;
  logic [18:0] len5;
  logic [15:0] mag5;
  logic [15:0] ux5, uy5;
  logic        neg5;
  logic [15:0] ux_u, uy_u;

  assign ux_u = {1'b0, uxm4};
  assign uy_u = {1'b0, uym4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v4   <= vld[MidDepth-1];
      v5   <= v4;
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (sd.zero) begin
      uxm4 <= '0;
      uym4 <= '0;
      len4 <= '0;
    end else begin
      uxm4 <= (ux_raw > WVD_UNIT_MAX) ? WVD_UNIT_MAX[14:0] : ux_raw[14:0];
      uym4 <= (uy_raw > WVD_UNIT_MAX) ? WVD_UNIT_MAX[14:0] : uy_raw[14:0];
      len4 <= len_q[18:0];
    end
    mag4 <= mag_d[WVD_QUO_BITS];
    ax4  <= sd.ax;
    ay4  <= sd.ay;
    sx4  <= sd.sx;
    sy4  <= sd.sy;

    mxx5 <= 31'(ax4 * uxm4);
    myy5 <= 31'(ay4 * uym4);
    mxy5 <= 31'(ax4 * uym4);
    len5 <= len4;
    mag5 <= mag4;
    ux5  <= sx4 ? 16'(~ux_u + 16'd1) : ux_u;
    uy5  <= sy4 ? 16'(~uy_u + 16'd1) : uy_u;
    // kx*ux and ky*uy carry matching signs, so only the cross term can go negative
    neg5 <= sx4 ^ sy4;
  end

  // stage p3: scale products back to q8.8 and drive the outputs
  logic [16:0] pxx, pyy, pxy;

  assign pxx = wvd_prod_clamp(mxx5[30:14]);
  assign pyy = wvd_prod_clamp(myy5[30:14]);
  assign pxy = wvd_prod_clamp(mxy5[30:14]);

  always_ff @(posedge clk) begin
    wavenumber  <= mag5;
    wavelength  <= len5;
    unit_x      <= ux5;
    unit_y      <= uy5;
    kx_times_ux <= pxx[15:0];
    ky_times_uy <= pyy[15:0];
    kx_times_uy <= neg5 ? 17'(~pxy + 17'd1) : pxy;
  end

endmodule
